/* design/sqd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared types and constants for the shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package sqd_pkg;

   localparam int CLIENT_W   = 16;
   localparam int SVC_W      = 8;
   localparam int TICK_W     = 32;
   localparam int REM_W      = 9;   // signed head count, -1 .. 255
   localparam int IDX_OUT_W  = 3;
   localparam int CFG_W      = 4;
   localparam int MAX_ACTIVE = 8;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   localparam logic REC_COMPLETION = 1'b0;
   localparam logic REC_STATUS     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ENQ,
      ST_CHECK,
      ST_HEAD,
      ST_NEXT,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic enq;
      logic check;
      logic head;
      logic next;
      logic status;
   } cmd_type;

   typedef struct packed {
      logic idx_last;   // walk index sits on the last active server
      logic complete;   // head job of the current server finishes
      logic more;       // queue still holds a job after the completion
   } sts_type;

   typedef struct packed {
      logic [CLIENT_W-1:0] client;
      logic [TICK_W-1:0]   arrival;
      logic [SVC_W-1:0]    service;
   } entry_type;

endpackage

/* design/sqd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_ctrl
// Sequencer for one tick: queue scan, enqueue, per-server countdown, status.
// ----------------------------------------------------------------------------
module sqd_ctrl
   import sqd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    arrival,
   output logic    busy,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = arrival ? ST_SCAN : ST_CHECK;
            end
         end
         ST_SCAN: begin
            if (sts.idx_last) begin
               state_in = ST_ENQ;
            end
         end
         ST_ENQ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.complete) begin
               state_in = ST_HEAD;
            end else if (sts.idx_last) begin
               state_in = ST_STATUS;
            end
         end
         ST_HEAD: begin
            if (sts.more) begin
               state_in = ST_NEXT;
            end else if (sts.idx_last) begin
               state_in = ST_STATUS;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_NEXT: begin
            state_in = sts.idx_last ? ST_STATUS : ST_CHECK;
         end
         ST_STATUS: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_ENQ:    cmd.enq    = 1'b1;
         ST_CHECK:  cmd.check  = 1'b1;
         ST_HEAD:   cmd.head   = 1'b1;
         ST_NEXT:   cmd.next   = 1'b1;
         ST_STATUS: cmd.status = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_SCAN || state_ff == ST_CHECK))
      else $error("accepted item did not begin a tick");

endmodule

/* design/sqd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_datapath
// Per-server queue state, job store and result registers.
// ----------------------------------------------------------------------------
module sqd_datapath
   import sqd_pkg::*;
#(
   parameter int SERVERS     = 8,
   parameter int QUEUE_DEPTH = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [CLIENT_W-1:0]  req_client_id,
   input  logic [SVC_W-1:0]     req_service_time,
   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_wr_data,
   output logic                 rsp_valid,
   output logic                 rsp_record_kind,
   output logic [IDX_OUT_W-1:0] rsp_server_index,
   output logic [CLIENT_W-1:0]  rsp_done_client,
   output logic [TICK_W-1:0]    rsp_wait_ticks,
   output logic [IDX_OUT_W-1:0] rsp_queue_chosen,
   output logic                 rsp_dropped,
   output logic                 rsp_all_empty,
   output logic                 rsp_last
);

   localparam int SW      = (SERVERS > 1) ? $clog2(SERVERS) : 1;
   localparam int PW      = $clog2(QUEUE_DEPTH);
   localparam int OW      = $clog2(QUEUE_DEPTH + 1);
   localparam int DEPTH   = SERVERS * QUEUE_DEPTH;
   localparam int AW      = $clog2(DEPTH);
   localparam int MAX_ACT = (SERVERS < MAX_ACTIVE) ? SERVERS : MAX_ACTIVE;

   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [OW-1:0] OCC_FULL = OW'(QUEUE_DEPTH);

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      ring_next = (p == PTR_LAST) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [AW-1:0] slot(input logic [SW-1:0] s,
                                          input logic [PW-1:0] p);
      slot = AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
   endfunction

   // registers
   logic [CFG_W-1:0]          cfg_ff, cfg_in;
   logic [TICK_W-1:0]         tick_ff, tick_in;
   logic [SW-1:0]             idx_ff, idx_in;
   logic [SW-1:0]             best_ff, best_in;
   logic                      drop_ff, drop_in;
   logic                      empty_ff, empty_in;
   logic [CLIENT_W-1:0]       client_ff, client_in;
   logic [SVC_W-1:0]          svc_ff, svc_in;
   logic [PW-1:0]             head_ff [SERVERS];
   logic [PW-1:0]             head_in [SERVERS];
   logic [PW-1:0]             tail_ff [SERVERS];
   logic [PW-1:0]             tail_in [SERVERS];
   logic [OW-1:0]             occ_ff  [SERVERS];
   logic [OW-1:0]             occ_in  [SERVERS];
   logic signed [REM_W-1:0]   rem_ff  [SERVERS];
   logic signed [REM_W-1:0]   rem_in  [SERVERS];
   entry_type                 rd_ff;

   logic                      valid_ff, valid_in;
   logic                      kind_ff, kind_in;
   logic [IDX_OUT_W-1:0]      srv_ff, srv_in;
   logic [CLIENT_W-1:0]       dclient_ff, dclient_in;
   logic [TICK_W-1:0]         wait_ff, wait_in;
   logic [IDX_OUT_W-1:0]      chosen_ff, chosen_in;
   logic                      odrop_ff, odrop_in;
   logic                      oempty_ff, oempty_in;
   logic                      last_ff, last_in;

   entry_type                 mem [DEPTH];

   // combinational
   logic [5:0]                act_w;
   logic [OW-1:0]             occ_i, occ_b, occ_dec;
   logic signed [REM_W-1:0]   rem_i, rem_dec;
   logic [PW-1:0]             head_i, head_nx;
   logic                      full_b, complete, more, adv;
   logic                      mem_we, mem_re;
   logic [AW-1:0]             wr_addr, rd_addr;
   entry_type                 wdata;

   always_comb begin
      if (cfg_ff == '0) begin
         act_w = 6'd1;
      end else if (6'(cfg_ff) > 6'(MAX_ACT)) begin
         act_w = 6'(MAX_ACT);
      end else begin
         act_w = 6'(cfg_ff);
      end
   end

   assign occ_i    = occ_ff[idx_ff];
   assign rem_i    = rem_ff[idx_ff];
   assign head_i   = head_ff[idx_ff];
   assign occ_b    = occ_ff[best_ff];
   assign full_b   = (occ_b == OCC_FULL);
   assign rem_dec  = rem_i - REM_W'(1);
   assign complete = (occ_i != '0) && rem_dec[REM_W-1];
   assign occ_dec  = occ_i - OW'(1);
   assign more     = (occ_dec != '0);
   assign head_nx  = ring_next(head_i);

   assign sts.idx_last = (6'(idx_ff) == act_w - 6'd1);
   assign sts.complete = complete;
   assign sts.more     = more;

   assign adv = (cmd.check && !complete) || (cmd.head && !more) || cmd.next;

   assign mem_we        = cmd.enq && !full_b;
   assign wr_addr       = slot(best_ff, tail_ff[best_ff]);
   assign wdata.client  = client_ff;
   assign wdata.arrival = tick_ff;
   assign wdata.service = svc_ff;
   assign mem_re        = (cmd.check && complete) || (cmd.head && more);
   assign rd_addr       = slot(idx_ff, cmd.head ? head_nx : head_i);

   always_comb begin
      cfg_in    = csr_wr_en ? csr_wr_data : cfg_ff;
      tick_in   = cmd.status ? tick_ff + TICK_W'(1) : tick_ff;
      client_in = cmd.load ? req_client_id : client_ff;
      svc_in    = cmd.load ? req_service_time : svc_ff;

      idx_in = idx_ff;
      if (cmd.load || cmd.enq) begin
         idx_in = '0;
      end else if (cmd.scan || adv) begin
         idx_in = idx_ff + SW'(1);
      end

      best_in = best_ff;
      if (cmd.load) begin
         best_in = '0;
      end else if (cmd.scan && (occ_i < occ_b)) begin
         best_in = idx_ff;
      end

      drop_in = drop_ff;
      if (cmd.load) begin
         drop_in = 1'b0;
      end else if (cmd.enq) begin
         drop_in = full_b;
      end

      empty_in = empty_ff;
      if (cmd.load) begin
         empty_in = 1'b1;
      end else if ((cmd.check && (occ_i != '0) && !complete) || cmd.next) begin
         empty_in = 1'b0;
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      rem_in  = rem_ff;
      if (mem_we) begin
         tail_in[best_ff] = ring_next(tail_ff[best_ff]);
         occ_in[best_ff]  = occ_b + OW'(1);
         if (occ_b == '0) begin
            rem_in[best_ff] = REM_W'({1'b0, svc_ff});
         end
      end
      if (cmd.check && (occ_i != '0) && !complete) begin
         rem_in[idx_ff] = rem_dec;
      end
      if (cmd.head) begin
         head_in[idx_ff] = head_nx;
         occ_in[idx_ff]  = occ_dec;
         if (!more) begin
            rem_in[idx_ff] = '0;
         end
      end
      if (cmd.next) begin
         // next job takes its first count in the same tick
         rem_in[idx_ff] = REM_W'({1'b0, rd_ff.service}) - REM_W'(1);
      end
   end

   always_comb begin
      valid_in   = cmd.head || cmd.status;
      kind_in    = kind_ff;
      srv_in     = srv_ff;
      dclient_in = dclient_ff;
      wait_in    = wait_ff;
      chosen_in  = chosen_ff;
      odrop_in   = odrop_ff;
      oempty_in  = oempty_ff;
      last_in    = last_ff;
      if (cmd.head) begin
         kind_in    = REC_COMPLETION;
         srv_in     = IDX_OUT_W'(idx_ff);
         dclient_in = rd_ff.client;
         wait_in    = tick_ff - TICK_W'(rd_ff.service) - rd_ff.arrival;
         chosen_in  = '0;
         odrop_in   = 1'b0;
         oempty_in  = 1'b0;
         last_in    = 1'b0;
      end else if (cmd.status) begin
         kind_in    = REC_STATUS;
         srv_in     = '0;
         dclient_in = '0;
         wait_in    = '0;
         chosen_in  = IDX_OUT_W'(best_ff);
         odrop_in   = drop_ff;
         oempty_in  = empty_ff;
         last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         tick_ff  <= '0;
         idx_ff   <= '0;
         best_ff  <= '0;
         drop_ff  <= 1'b0;
         empty_ff <= 1'b1;
         head_ff  <= '{default: '0};
         tail_ff  <= '{default: '0};
         occ_ff   <= '{default: '0};
         rem_ff   <= '{default: '0};
         valid_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         tick_ff  <= tick_in;
         idx_ff   <= idx_in;
         best_ff  <= best_in;
         drop_ff  <= drop_in;
         empty_ff <= empty_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      client_ff  <= client_in;
      svc_ff     <= svc_in;
      kind_ff    <= kind_in;
      srv_ff     <= srv_in;
      dclient_ff <= dclient_in;
      wait_ff    <= wait_in;
      chosen_ff  <= chosen_in;
      odrop_ff   <= odrop_in;
      oempty_ff  <= oempty_in;
      last_ff    <= last_in;
   end

   // job store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_record_kind  = kind_ff;
   assign rsp_server_index = srv_ff;
   assign rsp_done_client  = dclient_ff;
   assign rsp_wait_ticks   = wait_ff;
   assign rsp_queue_chosen = chosen_ff;
   assign rsp_dropped      = odrop_ff;
   assign rsp_all_empty    = oempty_ff;
   assign rsp_last         = last_ff;

   a_status_gap: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |=> !valid_ff)
      else $error("item output right after a status item");

   a_head_item: assert property (@(posedge clock) disable iff (reset)
      cmd.head |=> (valid_ff && (kind_ff == REC_COMPLETION)))
      else $error("completed job produced no completion item");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (occ_i != '0))
      else $error("job store read for an empty queue");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |-> (occ_b <= OCC_FULL))
      else $error("queue occupancy above depth");

endmodule

/* design/shortest_queue_dispatcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher
// Join-shortest-queue dispatcher: one tick per accepted item.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  req       start / busy         req_arrival_valid, req_client_id,
//                                 req_service_time
//  rsp       rsp_valid (strobe)   rsp_record_kind .. rsp_last
//  csr       csr_wr_en            csr_wr_data (servers_in_use)
//
// A tick walks the active servers once to pick the shortest queue when
// there is an arrival, then again to count down each head job; a job store
// read adds a step per completion and per queue that keeps a job. Items are
// registered and come out in the cycle after they are formed; the status
// item closes the tick and shows while busy is already low. Synchronous
// reset clears all queues, not the job store. No back-pressure on rsp.
// ----------------------------------------------------------------------------
module shortest_queue_dispatcher
   import sqd_pkg::*;
#(
   parameter int SERVERS     = 8,
   parameter int QUEUE_DEPTH = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_arrival_valid,
   input  logic [CLIENT_W-1:0]  req_client_id,
   input  logic [SVC_W-1:0]     req_service_time,
   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_wr_data,
   output logic                 rsp_valid,
   output logic                 rsp_record_kind,
   output logic [IDX_OUT_W-1:0] rsp_server_index,
   output logic [CLIENT_W-1:0]  rsp_done_client,
   output logic [TICK_W-1:0]    rsp_wait_ticks,
   output logic [IDX_OUT_W-1:0] rsp_queue_chosen,
   output logic                 rsp_dropped,
   output logic                 rsp_all_empty,
   output logic                 rsp_last
);

   cmd_type cmd;
   sts_type sts;

   sqd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .arrival (req_arrival_valid),
      .busy    (busy),
      .cmd     (cmd),
      .sts     (sts)
   );

   sqd_datapath #(
      .SERVERS     (SERVERS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_client_id    (req_client_id),
      .req_service_time (req_service_time),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_server_index (rsp_server_index),
      .rsp_done_client  (rsp_done_client),
      .rsp_wait_ticks   (rsp_wait_ticks),
      .rsp_queue_chosen (rsp_queue_chosen),
      .rsp_dropped      (rsp_dropped),
      .rsp_all_empty    (rsp_all_empty),
      .rsp_last         (rsp_last)
   );

endmodule
